[rtl/core/object_record_loader_unit_macros.svh]
// Assertion macros shared by the object record loader RTL.
`ifndef OBJECT_RECORD_LOADER_UNIT_MACROS_SVH
`define OBJECT_RECORD_LOADER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ORL_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("object record loader: assertion failed");

// Next-cycle implication, checked out of reset.
`define ORL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("object record loader: assertion failed");

`endif

[rtl/core/orl_pkg.sv]
// Shared types and constants of the object record loader.
package orl_pkg;

   localparam int CHAR_W = 8;
   localparam int ADDR_W = 24;
   localparam int DATA_W = 8;
   localparam int KIND_W = 2;

   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

   typedef struct packed {
      logic              valid;
      logic [KIND_W-1:0] kind;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] data;
   } orl_result_type;

endpackage

[rtl/core/orl_ifs.sv]
// Valid/ready channel interfaces for object characters and loader transactions.
interface orl_req_if import orl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] text_char;

   modport source (output valid, output text_char, input ready);
   modport sink (input valid, input text_char, output ready);
endinterface

interface orl_rsp_if import orl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [ADDR_W-1:0] address;
   logic [DATA_W-1:0] data;

   modport source (output valid, output kind, output address, output data, input ready);
   modport sink (input valid, input kind, input address, input data, output ready);
endinterface

[rtl/core/orl_parser.sv]
// Record parser: per-character state update and result generation.
module orl_parser import orl_pkg::*; #(
   parameter int MAX_LINE = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [CHAR_W-1:0] text_char,
   output orl_result_type    result
);

   localparam logic [2:0] REC_NONE = 3'd0;
   localparam logic [2:0] REC_H    = 3'd1;
   localparam logic [2:0] REC_T    = 3'd2;
   localparam logic [2:0] REC_E    = 3'd3;

   localparam logic [CHAR_W-1:0] CHAR_NL   = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_H    = 8'h48;
   localparam logic [CHAR_W-1:0] CHAR_T    = 8'h54;
   localparam logic [CHAR_W-1:0] CHAR_E    = 8'h45;
   localparam logic [CHAR_W-1:0] CASE_BIT  = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_A    = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_F    = 8'h66;

   localparam logic [7:0] LINE_LIMIT = 8'(MAX_LINE - 1);
   localparam logic [7:0] H_LEN      = 8'd19;
   localparam logic [7:0] E_LEN      = 8'd7;
   localparam logic [7:0] ADDR_END   = 8'd6;
   localparam logic [7:0] COUNT_END  = 8'd8;
   localparam logic [7:0] DATA_START = 8'd9;
   localparam logic [7:0] H_HEX_LO   = 8'd7;
   localparam logic [7:0] H_HEX_HI   = 8'd18;

   logic [2:0]        rec_kind_ff, rec_kind_in;
   logic [7:0]        column_ff, column_in;
   logic              header_ff, header_in;
   logic [ADDR_W-1:0] rec_addr_ff, rec_addr_in;
   logic [7:0]        count_ff, count_in;
   logic [3:0]        high_ff, high_in;
   logic [ADDR_W-1:0] entry_ff, entry_in;
   logic              stopped_ff, stopped_in;

   logic [CHAR_W-1:0] low_char;
   logic              hex_ok;
   logic [3:0]        hex_val;
   logic [9:0]        t_len;
   logic [7:0]        rel;

   always_comb begin
      low_char = text_char | CASE_BIT;
      hex_ok   = 1'b0;
      hex_val  = 4'd0;
      if (low_char >= CHAR_ZERO && low_char <= CHAR_NINE) begin
         hex_ok  = 1'b1;
         hex_val = 4'(low_char - CHAR_ZERO);
      end else if (low_char >= CHAR_A && low_char <= CHAR_F) begin
         hex_ok  = 1'b1;
         hex_val = 4'(low_char - CHAR_A + 8'd10);
      end
   end

   assign t_len = 10'(DATA_START) + {1'b0, count_ff, 1'b0};
   assign rel   = column_ff - DATA_START;

   always_comb begin
      rec_kind_in = rec_kind_ff;
      column_in   = column_ff;
      header_in   = header_ff;
      rec_addr_in = rec_addr_ff;
      count_in    = count_ff;
      high_in     = high_ff;
      entry_in    = entry_ff;
      stopped_in  = stopped_ff;
      result      = '0;
      if (!stopped_ff) begin
         if (text_char == CHAR_NL) begin
            column_in   = '0;
            rec_kind_in = REC_NONE;
            if (column_ff != '0) begin
               case (rec_kind_ff)
                  REC_H: begin
                     if (column_ff < H_LEN) begin
                        stopped_in   = 1'b1;
                        result.valid = 1'b1;
                        result.kind  = KIND_ERROR;
                     end else begin
                        header_in = 1'b1;
                     end
                  end
                  REC_T: begin
                     if ({2'b00, column_ff} < t_len) begin
                        stopped_in   = 1'b1;
                        result.valid = 1'b1;
                        result.kind  = KIND_ERROR;
                     end
                  end
                  REC_E: begin
                     result.valid = 1'b1;
                     if (column_ff < E_LEN) begin
                        stopped_in  = 1'b1;
                        result.kind = KIND_ERROR;
                     end else begin
                        result.kind    = KIND_ENTRY;
                        result.address = entry_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end else if (column_ff >= LINE_LIMIT) begin
            stopped_in   = 1'b1;
            result.valid = 1'b1;
            result.kind  = KIND_ERROR;
         end else begin
            column_in = column_ff + 8'd1;
            if (column_ff == '0) begin
               if (text_char == CHAR_H)
                  rec_kind_in = REC_H;
               else if (text_char == CHAR_T && header_ff)
                  rec_kind_in = REC_T;
               else if (text_char == CHAR_E && header_ff)
                  rec_kind_in = REC_E;
               else
                  rec_kind_in = REC_NONE;
            end else begin
               case (rec_kind_ff)
                  REC_H: begin
                     if (column_ff >= H_HEX_LO && column_ff <= H_HEX_HI && !hex_ok) begin
                        stopped_in   = 1'b1;
                        result.valid = 1'b1;
                        result.kind  = KIND_ERROR;
                     end
                  end
                  REC_T: begin
                     if (column_ff <= COUNT_END || {2'b00, column_ff} < t_len) begin
                        if (!hex_ok) begin
                           stopped_in   = 1'b1;
                           result.valid = 1'b1;
                           result.kind  = KIND_ERROR;
                        end else if (column_ff <= ADDR_END) begin
                           rec_addr_in = {rec_addr_ff[ADDR_W-5:0], hex_val};
                        end else if (column_ff <= COUNT_END) begin
                           count_in = {count_ff[3:0], hex_val};
                        end else if (!rel[0]) begin
                           high_in = hex_val;
                        end else begin
                           result.valid   = 1'b1;
                           result.kind    = KIND_WRITE;
                           result.address = rec_addr_ff + ADDR_W'(rel[7:1]);
                           result.data    = {high_ff, hex_val};
                        end
                     end
                  end
                  REC_E: begin
                     if (column_ff <= ADDR_END) begin
                        if (!hex_ok) begin
                           stopped_in   = 1'b1;
                           result.valid = 1'b1;
                           result.kind  = KIND_ERROR;
                        end else begin
                           entry_in = {entry_ff[ADDR_W-5:0], hex_val};
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_kind_ff <= REC_NONE;
         column_ff   <= '0;
         header_ff   <= 1'b0;
         rec_addr_ff <= '0;
         count_ff    <= '0;
         high_ff     <= '0;
         entry_ff    <= '0;
         stopped_ff  <= 1'b0;
      end else if (step) begin
         rec_kind_ff <= rec_kind_in;
         column_ff   <= column_in;
         header_ff   <= header_in;
         rec_addr_ff <= rec_addr_in;
         count_ff    <= count_in;
         high_ff     <= high_in;
         entry_ff    <= entry_in;
         stopped_ff  <= stopped_in;
      end
   end

`include "object_record_loader_unit_macros.svh"

   `ORL_ASSERT_NOW(a_stopped_quiet, stopped_ff, !result.valid)
   `ORL_ASSERT_NEXT(a_error_stops, step && result.valid && result.kind == KIND_ERROR, stopped_ff)
   `ORL_ASSERT_NOW(a_column_bound, 1'b1, column_ff <= LINE_LIMIT)

endmodule

[rtl/core/object_record_loader_unit.sv]
// Object record loader top level: input register, parser and result register.
// Takes one object-file character per transaction and emits memory byte writes,
// the entry point and a stop error as transactions on the result channel. A
// character is held in the input register, and the parser's result for it, if
// any, is registered in the result register; one character is taken every cycle
// while the result channel keeps up. A line longer than MAX_LINE-1 characters
// stops the loader; only reset restarts it.
module object_record_loader_unit import orl_pkg::*; #(
   parameter int MAX_LINE = 128
) (
   input  logic      clock,
   input  logic      reset,
   orl_req_if.sink   req_chan,
   orl_rsp_if.source rsp_chan
);

   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_char_ff;
   logic              out_valid_ff, out_valid_in;
   logic [KIND_W-1:0] out_kind_ff;
   logic [ADDR_W-1:0] out_addr_ff;
   logic [DATA_W-1:0] out_data_ff;
   logic              advance;
   logic              take;
   orl_result_type    result;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   orl_parser #(
      .MAX_LINE(MAX_LINE)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .text_char(in_char_ff),
      .result   (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take)
         in_valid_in = 1'b1;
      else if (advance)
         in_valid_in = 1'b0;
      out_valid_in = out_valid_ff;
      if (advance)
         out_valid_in = result.valid;
      else if (rsp_chan.ready)
         out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take)
         in_char_ff <= req_chan.text_char;
      if (advance && result.valid) begin
         out_kind_ff <= result.kind;
         out_addr_ff <= result.address;
         out_data_ff <= result.data;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.kind    = out_kind_ff;
   assign rsp_chan.address = out_addr_ff;
   assign rsp_chan.data    = out_data_ff;

endmodule
